// File: rtl/bfba_pkg.sv
`default_nettype none

package bfba_pkg;

  localparam int MAX_BLOCKS  = 4096;
  localparam int BLK_W       = 13;
  localparam int BM_BYTES    = (MAX_BLOCKS + 7) / 8;
  localparam int BM_AW       = $clog2(BM_BYTES);
  localparam int STK_AW      = $clog2(MAX_BLOCKS);
  localparam int TOTAL_RESET = 4096;

  localparam logic [2:0] CMD_LOAD      = 3'd0;
  localparam logic [2:0] CMD_READ      = 3'd1;
  localparam logic [2:0] CMD_REBUILD   = 3'd2;
  localparam logic [2:0] CMD_MARK_USED = 3'd3;
  localparam logic [2:0] CMD_MARK_FREE = 3'd4;
  localparam logic [2:0] CMD_ALLOC     = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] block_index;
    logic [8:0]  byte_index;
    logic [7:0]  byte_in;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [12:0] allocated_block;
    logic [7:0]  byte_out;
    logic [12:0] free_count;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MARK,
    ST_POP,
    ST_ALLOC_WR,
    ST_SCAN_RD,
    ST_SCAN_BIT,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_READ,
    OP_MARK,
    OP_POP,
    OP_ALLOC_WR,
    OP_SCAN_RD,
    OP_SCAN_BIT,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic blk_ok;
    logic pop_ok;
    logic total_zero;
    logic pop_valid;
    logic scan_last;
    logic scan_byte_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/bfba_ram.sv
`default_nettype none

module bfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/bfba_ctrl.sv
`default_nettype none

module bfba_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [2:0]            in_cmd,
  input  wire bfba_pkg::dp_status_t  status,
  output logic                       in_ready,
  output bfba_pkg::ctrl_cmd_t        cmd
);

  bfba_pkg::state_t state;
  bfba_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfba_pkg::ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = bfba_pkg::ST_IDLE;
        end
      end
      bfba_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority case (in_cmd)
            bfba_pkg::CMD_READ:    state_next = bfba_pkg::ST_READ;
            bfba_pkg::CMD_REBUILD: begin
              state_next = status.total_zero ? bfba_pkg::ST_DONE : bfba_pkg::ST_SCAN_RD;
            end
            bfba_pkg::CMD_MARK_USED, bfba_pkg::CMD_MARK_FREE: begin
              state_next = status.blk_ok ? bfba_pkg::ST_MARK : bfba_pkg::ST_DONE;
            end
            bfba_pkg::CMD_ALLOC: begin
              state_next = status.pop_ok ? bfba_pkg::ST_POP : bfba_pkg::ST_DONE;
            end
            default:               state_next = bfba_pkg::ST_DONE;
          endcase
        end
      end
      bfba_pkg::ST_READ:     state_next = bfba_pkg::ST_DONE;
      bfba_pkg::ST_MARK:     state_next = bfba_pkg::ST_DONE;
      bfba_pkg::ST_POP: begin
        state_next = status.pop_valid ? bfba_pkg::ST_ALLOC_WR : bfba_pkg::ST_DONE;
      end
      bfba_pkg::ST_ALLOC_WR: state_next = bfba_pkg::ST_DONE;
      bfba_pkg::ST_SCAN_RD:  state_next = bfba_pkg::ST_SCAN_BIT;
      bfba_pkg::ST_SCAN_BIT: begin
        if (status.scan_last) begin
          state_next = bfba_pkg::ST_DONE;
        end else if (status.scan_byte_end) begin
          state_next = bfba_pkg::ST_SCAN_RD;
        end
      end
      bfba_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_next = bfba_pkg::ST_IDLE;
        end
      end
      default: state_next = bfba_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = bfba_pkg::OP_NONE;
    unique case (state)
      bfba_pkg::ST_CLEAR:    cmd.op = bfba_pkg::OP_CLEAR;
      bfba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? bfba_pkg::OP_ACCEPT : bfba_pkg::OP_NONE;
      end
      bfba_pkg::ST_READ:     cmd.op = bfba_pkg::OP_READ;
      bfba_pkg::ST_MARK:     cmd.op = bfba_pkg::OP_MARK;
      bfba_pkg::ST_POP:      cmd.op = bfba_pkg::OP_POP;
      bfba_pkg::ST_ALLOC_WR: cmd.op = bfba_pkg::OP_ALLOC_WR;
      bfba_pkg::ST_SCAN_RD:  cmd.op = bfba_pkg::OP_SCAN_RD;
      bfba_pkg::ST_SCAN_BIT: cmd.op = bfba_pkg::OP_SCAN_BIT;
      bfba_pkg::ST_DONE: begin
        cmd.op = status.out_free ? bfba_pkg::OP_DONE : bfba_pkg::OP_NONE;
      end
      default:               cmd.op = bfba_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bfba_dp.sv
`default_nettype none

module bfba_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [12:0]          cfg_wr_data,
  input  wire bfba_pkg::in_word_t   in_data,
  input  wire bfba_pkg::ctrl_cmd_t  cmd,
  input  wire logic                 out_ready,
  output bfba_pkg::dp_status_t      status,
  output logic                      out_valid,
  output bfba_pkg::out_word_t       out_data
);

  localparam int BW = bfba_pkg::BLK_W;
  localparam int AW = bfba_pkg::BM_AW;
  localparam int SW = bfba_pkg::STK_AW;
  localparam logic [BW-1:0] MAX_B = BW'(bfba_pkg::MAX_BLOCKS);

  function automatic logic [AW-1:0] byte_of(input logic [BW-1:0] b);
    logic [BW-1:0] bm1;
    bm1 = b - BW'(1);
    return bm1[AW+2:3];
  endfunction

  function automatic logic [2:0] pos_of(input logic [BW-1:0] b);
    logic [BW-1:0] bm1;
    bm1 = b - BW'(1);
    return bm1[2:0];
  endfunction

  logic [BW-1:0]      total;
  logic               bound;
  logic [BW-1:0]      depth;
  logic [BW-1:0]      depth_next;
  logic [AW-1:0]      clr_addr;
  bfba_pkg::in_word_t item;
  logic [BW-1:0]      blk;
  logic [BW-1:0]      pop_val;
  logic               res_ok;
  logic [BW-1:0]      res_alloc;
  logic [7:0]         res_bout;

  logic [BW-1:0] eff_total;
  logic          acc;
  logic          in_addr_ok;
  logic          item_addr_ok;
  logic          stk_room;
  logic          push;

  logic          bm_we;
  logic [AW-1:0] bm_waddr;
  logic [7:0]    bm_wdata;
  logic [AW-1:0] bm_raddr;
  logic [7:0]    bm_rdata;
  logic          stk_we;
  logic [BW-1:0] stk_wdata;
  logic [SW-1:0] stk_raddr;
  logic [BW-1:0] stk_rdata;
  logic [BW-1:0] depth_m1;

  assign eff_total    = (total > MAX_B) ? MAX_B : total;
  assign acc          = (cmd.op == bfba_pkg::OP_ACCEPT);
  assign in_addr_ok   = ({1'b0, in_data.byte_index} < 10'(bfba_pkg::BM_BYTES));
  assign item_addr_ok = ({1'b0, item.byte_index} < 10'(bfba_pkg::BM_BYTES));
  assign stk_room     = (depth < MAX_B);
  assign depth_m1     = depth - BW'(1);
  assign stk_raddr    = depth_m1[SW-1:0];

  assign status.clear_last    = (clr_addr == AW'(bfba_pkg::BM_BYTES - 1));
  assign status.blk_ok        = bound && (in_data.block_index != '0) &&
                                (in_data.block_index <= eff_total);
  assign status.pop_ok        = bound && (depth != '0);
  assign status.total_zero    = (eff_total == '0);
  assign status.pop_valid     = bound && (stk_rdata != '0) && (stk_rdata <= eff_total);
  assign status.scan_last     = (blk == eff_total);
  assign status.scan_byte_end = (blk[2:0] == 3'd0);
  assign status.out_free      = !out_valid || out_ready;

  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = byte_of(item.block_index);
    bm_wdata  = 8'd0;
    bm_raddr  = byte_of(item.block_index);
    stk_we    = 1'b0;
    stk_wdata = blk;
    push      = 1'b0;
    unique case (cmd.op)
      bfba_pkg::OP_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_addr;
      end
      bfba_pkg::OP_ACCEPT: begin
        if (in_data.cmd == bfba_pkg::CMD_READ) begin
          bm_raddr = in_data.byte_index[AW-1:0];
        end else begin
          bm_raddr = byte_of(in_data.block_index);
        end
        if (in_data.cmd == bfba_pkg::CMD_LOAD && in_addr_ok) begin
          bm_we    = 1'b1;
          bm_waddr = in_data.byte_index[AW-1:0];
          bm_wdata = in_data.byte_in;
        end
      end
      bfba_pkg::OP_MARK: begin
        bm_we = 1'b1;
        if (item.cmd == bfba_pkg::CMD_MARK_USED) begin
          bm_wdata = bm_rdata | (8'd1 << pos_of(item.block_index));
        end else begin
          bm_wdata = bm_rdata & ~(8'd1 << pos_of(item.block_index));
          if (bm_rdata[pos_of(item.block_index)] && stk_room) begin
            stk_we    = 1'b1;
            stk_wdata = item.block_index;
            push      = 1'b1;
          end
        end
      end
      bfba_pkg::OP_POP: begin
        bm_raddr = byte_of(stk_rdata);
      end
      bfba_pkg::OP_ALLOC_WR: begin
        bm_we    = 1'b1;
        bm_waddr = byte_of(pop_val);
        bm_raddr = byte_of(pop_val);
        bm_wdata = bm_rdata | (8'd1 << pos_of(pop_val));
      end
      bfba_pkg::OP_SCAN_RD: begin
        bm_raddr = byte_of(blk);
      end
      bfba_pkg::OP_SCAN_BIT: begin
        bm_raddr = byte_of(blk);
        if (!bm_rdata[pos_of(blk)] && stk_room) begin
          stk_we = 1'b1;
          push   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    depth_next = depth;
    if (acc && in_data.cmd == bfba_pkg::CMD_REBUILD) begin
      depth_next = '0;
    end else if (acc && in_data.cmd == bfba_pkg::CMD_ALLOC && status.pop_ok) begin
      depth_next = depth_m1;
    end else if (push) begin
      depth_next = depth + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= BW'(bfba_pkg::TOTAL_RESET);
      bound     <= 1'b0;
      depth     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        total <= cfg_wr_data;
      end
      if (acc && in_data.cmd == bfba_pkg::CMD_REBUILD) begin
        bound <= 1'b1;
      end
      depth <= depth_next;
      if (cmd.op == bfba_pkg::OP_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.op == bfba_pkg::OP_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bfba_pkg::OP_ACCEPT: begin
        item      <= in_data;
        blk       <= BW'(1);
        res_alloc <= '0;
        res_bout  <= '0;
        res_ok    <= ((in_data.cmd == bfba_pkg::CMD_LOAD) && in_addr_ok) ||
                     (in_data.cmd == bfba_pkg::CMD_REBUILD);
      end
      bfba_pkg::OP_READ: begin
        res_ok   <= item_addr_ok;
        res_bout <= item_addr_ok ? bm_rdata : 8'd0;
      end
      bfba_pkg::OP_MARK: begin
        res_ok <= 1'b1;
      end
      bfba_pkg::OP_POP: begin
        pop_val <= stk_rdata;
      end
      bfba_pkg::OP_ALLOC_WR: begin
        res_ok    <= 1'b1;
        res_alloc <= pop_val;
      end
      bfba_pkg::OP_SCAN_BIT: begin
        blk <= blk + BW'(1);
      end
      bfba_pkg::OP_DONE: begin
        out_data.ok              <= res_ok;
        out_data.allocated_block <= res_alloc;
        out_data.byte_out        <= res_bout;
        out_data.free_count      <= depth;
      end
      default: begin
      end
    endcase
  end

  bfba_ram #(
    .WIDTH (8),
    .DEPTH (bfba_pkg::BM_BYTES)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bfba_ram #(
    .WIDTH (BW),
    .DEPTH (bfba_pkg::MAX_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth[SW-1:0]),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/bitmap_free_block_allocator_unit.sv
// Load and unused codes go from IDLE straight to DONE, read through READ, mark through MARK
// (straight to DONE when refused), allocate through POP and ALLOC_WR (DONE early when
// refused). Rebuild scans the effective total, one bitmap bit per cycle plus one bitmap RAM
// read per byte. One word is in work at a time; the next is taken once the result is in the
// output register. Synchronous reset clears the control state, then the bitmap RAM's 512
// bytes are cleared one byte a cycle while in_ready stays low.
`default_nettype none

module bitmap_free_block_allocator_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [12:0]         cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bfba_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bfba_pkg::out_word_t      out_data
);

  bfba_pkg::ctrl_cmd_t  cmd;
  bfba_pkg::dp_status_t status;

  bfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bfba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .out_ready   (out_ready),
    .status      (status),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

`ifndef NO_ASSERTIONS
  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a word was accepted");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.free_count <= 13'(bfba_pkg::MAX_BLOCKS))
    else $error("free_count exceeds the stack depth");

  a_alloc_implies_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.allocated_block != '0) |-> out_data.ok)
    else $error("block handed out on a failed command");

  a_no_accept_while_done: assert property (@(posedge clk) disable iff (rst)
    cmd.op == bfba_pkg::OP_DONE |-> !in_ready)
    else $error("result loaded while a new word could be taken");
`endif

endmodule

`default_nettype wire

// File: tb/bitmap_free_block_allocator_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_free_block_allocator_unit_tb;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 75;
  localparam logic [12:0] PHASE_TOTALS [PHASES] = '{
    13'd1, 13'd8191, 13'd13, 13'd4096, 13'd64, 13'd0,
    13'd4095, 13'd200, 13'd8, 13'd5000, 13'd37, 13'd2
  };

  class allocator_mirror;
    logic [7:0] used_map [bfba_pkg::BM_BYTES];
    logic [12:0] free_list [bfba_pkg::MAX_BLOCKS];
    int unsigned depth;
    bit rebuilt;
    logic [12:0] total;
    bfba_pkg::out_word_t owed_replies [$];
    int errors;

    function new();
      foreach (used_map[i]) used_map[i] = 8'h00;
      depth = 0;
      rebuilt = 1'b0;
      total = 13'(bfba_pkg::TOTAL_RESET);
      errors = 0;
    endfunction

    function int unsigned live_total();
      return (total > bfba_pkg::MAX_BLOCKS) ? bfba_pkg::MAX_BLOCKS : total;
    endfunction

    function bit in_range(int unsigned b);
      return rebuilt && b != 0 && b <= live_total();
    endfunction

    function bit is_used(int unsigned b);
      return used_map[(b - 1) >> 3][(b - 1) % 8];
    endfunction

    function void set_used(int unsigned b, bit v);
      used_map[(b - 1) >> 3][(b - 1) % 8] = v;
    endfunction

    function void push_free(int unsigned b);
      if (depth < bfba_pkg::MAX_BLOCKS) begin
        free_list[depth] = 13'(b);
        depth++;
      end
    endfunction

    function void note_command(bfba_pkg::in_word_t w);
      bfba_pkg::out_word_t r;
      int unsigned b;
      int unsigned t;
      r = '0;
      b = w.block_index;
      case (w.cmd)
        bfba_pkg::CMD_LOAD: begin
          used_map[w.byte_index] = w.byte_in;
          r.ok = 1'b1;
        end
        bfba_pkg::CMD_READ: begin
          r.byte_out = used_map[w.byte_index];
          r.ok = 1'b1;
        end
        bfba_pkg::CMD_REBUILD: begin
          t = live_total();
          depth = 0;
          for (int unsigned i = 1; i <= t; i++) begin
            if (!is_used(i)) push_free(i);
          end
          rebuilt = 1'b1;
          r.ok = 1'b1;
        end
        bfba_pkg::CMD_MARK_USED: begin
          if (in_range(b)) begin
            set_used(b, 1'b1);
            r.ok = 1'b1;
          end
        end
        bfba_pkg::CMD_MARK_FREE: begin
          if (in_range(b)) begin
            if (is_used(b)) begin
              set_used(b, 1'b0);
              push_free(b);
            end
            r.ok = 1'b1;
          end
        end
        bfba_pkg::CMD_ALLOC: begin
          if (rebuilt && depth > 0) begin
            depth--;
            b = free_list[depth];
            if (in_range(b)) begin
              set_used(b, 1'b1);
              r.allocated_block = 13'(b);
              r.ok = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      r.free_count = 13'(depth);
      owed_replies.push_back(r);
    endfunction

    task report(string what, int got, int want);
      if (errors < 40) $display("%0t: %s got %0d, want %0d", $time, what, got, want);
      errors++;
    endtask

    task check_reply(bfba_pkg::out_word_t got);
      bfba_pkg::out_word_t want;
      if (owed_replies.size() == 0) begin
        report("unexpected reply, ok", got.ok, 0);
      end else begin
        want = owed_replies.pop_front();
        if (got.ok !== want.ok) report("ok", got.ok, want.ok);
        if (got.allocated_block !== want.allocated_block)
          report("allocated_block", got.allocated_block, want.allocated_block);
        if (got.byte_out !== want.byte_out) report("byte_out", got.byte_out, want.byte_out);
        if (got.free_count !== want.free_count)
          report("free_count", got.free_count, want.free_count);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  bfba_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bfba_pkg::out_word_t out_data;

  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  allocator_mirror mirror;

  bitmap_free_block_allocator_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) mirror.check_reply(out_data);
      if (in_valid && in_ready) mirror.note_command(in_data);
    end
  end

  task automatic send_word(input bfba_pkg::in_word_t w);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [2:0] c, input logic [12:0] b, input logic [8:0] a,
                          input logic [7:0] v);
    bfba_pkg::in_word_t w;
    w = '{cmd: c, block_index: b, byte_index: a, byte_in: v};
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_total(input logic [12:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror.total = v;
  endtask

  function automatic bfba_pkg::in_word_t random_command();
    bfba_pkg::in_word_t w;
    int unsigned lim;
    int unsigned nbytes;
    int unsigned r;
    lim = mirror.live_total();
    nbytes = (lim + 7) / 8;
    r = $urandom_range(0, 99);
    if (r < 12) w.cmd = bfba_pkg::CMD_LOAD;
    else if (r < 24) w.cmd = bfba_pkg::CMD_READ;
    else if (r < 26) w.cmd = bfba_pkg::CMD_REBUILD;
    else if (r < 46) w.cmd = bfba_pkg::CMD_MARK_USED;
    else if (r < 68) w.cmd = bfba_pkg::CMD_MARK_FREE;
    else if (r < 96) w.cmd = bfba_pkg::CMD_ALLOC;
    else w.cmd = (r % 2 == 0) ? CMD_SPARE_A : CMD_SPARE_B;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      w.block_index = 13'($urandom);
    end else if (r == 1) begin
      case ($urandom_range(0, 2))
        0: w.block_index = 13'd0;
        1: w.block_index = 13'(lim);
        default: w.block_index = 13'(lim + 1);
      endcase
    end else begin
      w.block_index = (lim == 0) ? 13'd0 : 13'($urandom_range(1, lim));
    end
    if (nbytes == 0 || $urandom_range(0, 4) == 0) w.byte_index = 9'($urandom);
    else w.byte_index = 9'($urandom_range(0, nbytes - 1));
    r = $urandom_range(0, 7);
    w.byte_in = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
    return w;
  endfunction

  initial begin : reply_side
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 29) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    mirror = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Nothing may be marked or allocated before the first rebuild.
    send_cmd(bfba_pkg::CMD_ALLOC, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_USED, 13'd1, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_FREE, 13'd4096, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_LOAD, 13'd0, 9'd0, 8'hA5);
    send_cmd(bfba_pkg::CMD_LOAD, 13'd0, 9'd511, 8'hFF);
    send_cmd(bfba_pkg::CMD_READ, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_READ, 13'd8191, 9'd511, 8'hFF);
    send_cmd(bfba_pkg::CMD_READ, 13'd0, 9'd300, 8'h00);
    send_cmd(CMD_SPARE_A, 13'd8191, 9'd511, 8'hFF);
    send_cmd(CMD_SPARE_B, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_REBUILD, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_USED, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_USED, 13'd4097, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_FREE, 13'd8191, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_USED, 13'd4088, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_ALLOC, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_FREE, 13'd2, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_FREE, 13'd1, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_ALLOC, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_LOAD, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_LOAD, 13'd0, 9'd511, 8'h00);
    send_cmd(bfba_pkg::CMD_REBUILD, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_USED, 13'd4096, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_FREE, 13'd4096, 9'd0, 8'h00);

    // Shrinking the total leaves high blocks on the stack that no longer fit.
    write_total(13'd100);
    send_cmd(bfba_pkg::CMD_ALLOC, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_ALLOC, 13'd0, 9'd0, 8'h00);
    write_total(13'd0);
    send_cmd(bfba_pkg::CMD_REBUILD, 13'd0, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_MARK_USED, 13'd1, 9'd0, 8'h00);
    send_cmd(bfba_pkg::CMD_ALLOC, 13'd0, 9'd0, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      write_total(PHASE_TOTALS[p]);
      if ($urandom_range(0, 3) != 0)
        send_cmd(bfba_pkg::CMD_REBUILD, 13'($urandom), 9'($urandom), 8'($urandom));
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        send_word(random_command());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mirror.owed_replies.size() != 0)
      mirror.report("replies still missing", mirror.owed_replies.size(), 0);
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
